// File: src/sle_pkg.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Package
// Shared types and constants for the sprite list tile expander.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam int SPRITE_WORDS_DEFAULT = 2048;

   localparam int WORD_W   = 16;
   localparam int ADDR_IN_W = 11;
   localparam int POS_W    = 12;
   localparam int CODE_W   = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_FRAME  = 2'd1,
      OP_STEP   = 2'd2,
      OP_IGNORE = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRI_MATCH = 2'd0,
      CSR_PRI_MASK  = 2'd1,
      CSR_FLIP      = 2'd2,
      CSR_HSHIFT    = 2'd3
   } csr_idx_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [POS_W-1:0]  a;
      logic [POS_W-1:0]  b;
   } alu_req_type;

   localparam logic [2:0] WORD_TAG  = 3'd0;
   localparam logic [2:0] WORD_SIZE = 3'd1;
   localparam logic [2:0] WORD_CODE = 3'd3;
   localparam logic [2:0] WORD_XPOS = 3'd4;
   localparam logic [2:0] WORD_YPOS = 3'd6;
   localparam logic [2:0] WORD_ATTR = 3'd7;

   localparam logic [POS_W-1:0] X_MIRROR      = 12'd368;
   localparam logic [POS_W-1:0] Y_MIRROR      = 12'd240;
   localparam logic [POS_W-1:0] TILE_STEP     = 12'd16;
   localparam logic [POS_W-1:0] TILE_STEP_NEG = 12'hff0;

endpackage

// File: src/sle_req_if.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Request Channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface sle_req_if;

   logic                             valid;
   logic                             ready;
   sle_pkg::op_type                  opcode;
   logic [sle_pkg::ADDR_IN_W-1:0]    word_address;
   logic [sle_pkg::WORD_W-1:0]       word_data;

   modport source (output valid, opcode, word_address, word_data, input ready);
   modport sink   (input valid, opcode, word_address, word_data, output ready);

endinterface

// File: src/sle_rsp_if.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Response Channel
// Valid/ready channel that carries one tile draw or an end-of-pass marker.
// ----------------------------------------------------------------------------
interface sle_rsp_if;

   logic                          valid;
   logic                          ready;
   logic                          tile_valid;
   logic                          pass_done;
   logic [sle_pkg::CODE_W-1:0]    tile_code;
   logic [sle_pkg::WORD_W-1:0]    color_word;
   logic signed [9:0]             pos_x;
   logic [8:0]                    pos_y;
   logic                          tile_flip;

   modport source (output valid, tile_valid, pass_done, tile_code, color_word, pos_x,
                   pos_y, tile_flip, input ready);
   modport sink   (input valid, tile_valid, pass_done, tile_code, color_word, pos_x,
                   pos_y, tile_flip, output ready);

endinterface

// File: src/sle_ram.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Word Bank
// One sprite word bank with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sle_ram #(
   parameter int DEPTH  = sle_pkg::SPRITE_WORDS_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [sle_pkg::WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [sle_pkg::WORD_W-1:0] rd_data
);

   logic [sle_pkg::WORD_W-1:0] mem [DEPTH];
   logic [sle_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/sle_alu.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Position Unit
// Shared 12-bit add/subtract unit for entry start positions and tile steps.
// ----------------------------------------------------------------------------
module sle_alu (
   input  sle_pkg::alu_req_type         req,
   output logic [sle_pkg::POS_W-1:0]    result
);

   always_comb begin
      case (req.op)
         sle_pkg::ALU_ADD: result = req.a + req.b;
         sle_pkg::ALU_SUB: result = req.a - req.b;
         default:          result = req.a + req.b;
      endcase
   end

endmodule

// File: src/sprite_list_tile_expander.sv
// ----------------------------------------------------------------------------
// Sprite List Tile Expander
// Keeps a live sprite list and two delayed copies in three rotating banks,
// walks the oldest copy entry by entry and hands out one 16x16 tile, or an end-of-pass marker, per step.
//
//   Channel    Direction  Transfer carries
//   req_chan   in         opcode, word_address, word_data
//   rsp_chan   out        tile_valid, pass_done, tile_code, color_word,
//                         pos_x, pos_y, tile_flip
//   csr_*      in         csr_index, csr_wdata (write only)
//
// A word write goes straight into the live bank. A frame end rotates the
// banks and copies the live list into a free bank, one word per cycle.
// Starting an entry reads its tag, attribute, size, code, x and y words in
// turn through the single read port and uses the shared position unit to
// add the horizontal shift to x and, with flip, to mirror x and y. A skipped
// entry stops after its tag or attribute read. After reset a clearing pass
// zeroes all banks; req_chan.ready stays low then.
// The result register lets the next request transfer while a result waits.
// ----------------------------------------------------------------------------
module sprite_list_tile_expander #(
   parameter int SPRITE_WORDS = sle_pkg::SPRITE_WORDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   sle_req_if.sink                           req_chan,
   sle_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [sle_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sle_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W      = $clog2(SPRITE_WORDS);
   localparam int CNT_W       = $clog2(SPRITE_WORDS + 1);
   localparam int NUM_ENTRIES = (SPRITE_WORDS + 7) / 8;
   localparam int ENTRY_W     = $clog2(NUM_ENTRIES + 1);
   localparam int SCAN_W      = ENTRY_W + 3;
   localparam int POS_W       = sle_pkg::POS_W;
   localparam int WORD_W      = sle_pkg::WORD_W;
   localparam int CODE_W      = sle_pkg::CODE_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_COPY,
      ST_SCAN,
      ST_W0,
      ST_W7,
      ST_W1,
      ST_W3,
      ST_W4,
      ST_W6,
      ST_FLIP_X,
      ST_FLIP_Y,
      ST_TILE,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  cp_pend_ff, cp_pend_in;
   logic [ADDR_W-1:0]     cp_addr_ff, cp_addr_in;
   logic [1:0]            live_sel_ff, live_sel_in;
   logic [1:0]            d1_sel_ff, d1_sel_in;
   logic [1:0]            d2_sel_ff, d2_sel_in;
   logic [7:0]            match_ff, match_in;
   logic [7:0]            mask_ff, mask_in;
   logic                  flip_ff, flip_in;
   logic [8:0]            hshift_ff, hshift_in;
   logic [ENTRY_W-1:0]    entry_ff, entry_in;
   logic                  expanding_ff, expanding_in;
   logic [3:0]            col_ff, col_in;
   logic [3:0]            row_ff, row_in;
   logic [3:0]            width_ff, width_in;
   logic [POS_W-1:0]      row_x_ff, row_x_in;
   logic [POS_W-1:0]      cur_x_ff, cur_x_in;
   logic [POS_W-1:0]      cur_y_ff, cur_y_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [WORD_W-1:0]     color_ff, color_in;
   logic                  eflip_ff, eflip_in;
   logic                  oob_ff, oob_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_tile_ff, rsp_tile_in;
   logic                  rsp_done_ff, rsp_done_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic [WORD_W-1:0]     rsp_color_ff, rsp_color_in;
   logic [9:0]            rsp_x_ff, rsp_x_in;
   logic [8:0]            rsp_y_ff, rsp_y_in;
   logic                  rsp_flip_ff, rsp_flip_in;

   logic                  req_accept;
   logic                  slot_free;
   logic                  wr_in_range;
   logic                  clearing;
   logic [2:0]            word_sel;
   logic [SCAN_W-1:0]     scan_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [2:0]            bank_we;
   logic [WORD_W-1:0]     bank_rd [3];
   logic [WORD_W-1:0]     d1_word;
   logic [WORD_W-1:0]     d2_word;
   logic [WORD_W-1:0]     scan_word;
   logic [POS_W-1:0]      delta;
   logic [8:0]            x_wrap;
   sle_pkg::alu_req_type  alu_req;
   logic [POS_W-1:0]      alu_res;

   assign req_accept  = req_chan.valid && req_chan.ready;
   assign slot_free   = !rsp_valid_ff || rsp_chan.ready;
   assign wr_in_range = int'(req_chan.word_address) < SPRITE_WORDS;
   assign clearing    = (state_ff == ST_CLEAR);

   // Word offset within the entry fetched in each scan state.
   always_comb begin
      case (state_ff)
         ST_SCAN: word_sel = sle_pkg::WORD_TAG;
         ST_W0:   word_sel = sle_pkg::WORD_ATTR;
         ST_W7:   word_sel = sle_pkg::WORD_SIZE;
         ST_W1:   word_sel = sle_pkg::WORD_CODE;
         ST_W3:   word_sel = sle_pkg::WORD_XPOS;
         ST_W4:   word_sel = sle_pkg::WORD_YPOS;
         default: word_sel = sle_pkg::WORD_TAG;
      endcase
   end

   assign scan_addr = {entry_ff, word_sel};
   assign oob_in    = scan_addr >= SCAN_W'(SPRITE_WORDS);
   assign rd_addr   = (state_ff == ST_COPY) ? cnt_ff[ADDR_W-1:0] : scan_addr[ADDR_W-1:0];

   always_comb begin
      if (clearing) begin
         wr_addr = cnt_ff[ADDR_W-1:0];
         wr_data = '0;
      end else if (cp_pend_ff) begin
         wr_addr = cp_addr_ff;
         wr_data = d1_word;
      end else begin
         wr_addr = ADDR_W'(req_chan.word_address);
         wr_data = req_chan.word_data;
      end
   end

   for (genvar b = 0; b < 3; b++) begin : g_bank
      assign bank_we[b] = clearing
                       || (cp_pend_ff && live_sel_ff == 2'(b))
                       || (req_accept && req_chan.opcode == sle_pkg::OP_WRITE
                           && wr_in_range && live_sel_ff == 2'(b));

      sle_ram #(
         .DEPTH  (SPRITE_WORDS),
         .ADDR_W (ADDR_W)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_addr (rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   always_comb begin
      case (d1_sel_ff)
         2'd0:    d1_word = bank_rd[0];
         2'd1:    d1_word = bank_rd[1];
         2'd2:    d1_word = bank_rd[2];
         default: d1_word = '0;
      endcase
      case (d2_sel_ff)
         2'd0:    d2_word = bank_rd[0];
         2'd1:    d2_word = bank_rd[1];
         2'd2:    d2_word = bank_rd[2];
         default: d2_word = '0;
      endcase
   end

   assign scan_word = oob_ff ? '0 : d2_word;
   assign delta     = eflip_ff ? sle_pkg::TILE_STEP_NEG : sle_pkg::TILE_STEP;
   assign x_wrap    = cur_x_ff[8:0] + 9'd16;

   // Operand selection for the shared position unit.
   always_comb begin
      alu_req.op = sle_pkg::ALU_ADD;
      alu_req.a  = cur_x_ff;
      alu_req.b  = delta;
      case (state_ff)
         ST_W4: begin
            alu_req.a = {3'b000, scan_word[8:0]};
            alu_req.b = {3'b000, hshift_ff};
         end
         ST_FLIP_X: begin
            alu_req.op = sle_pkg::ALU_SUB;
            alu_req.a  = sle_pkg::X_MIRROR;
            alu_req.b  = row_x_ff;
         end
         ST_FLIP_Y: begin
            alu_req.op = sle_pkg::ALU_SUB;
            alu_req.a  = sle_pkg::Y_MIRROR;
            alu_req.b  = cur_y_ff;
         end
         ST_TILE: begin
            alu_req.a = (col_ff != 4'd0) ? cur_x_ff : cur_y_ff;
         end
         default: begin
            alu_req.a = cur_x_ff;
         end
      endcase
   end

   sle_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cp_pend_in   = 1'b0;
      cp_addr_in   = cp_addr_ff;
      live_sel_in  = live_sel_ff;
      d1_sel_in    = d1_sel_ff;
      d2_sel_in    = d2_sel_ff;
      match_in     = match_ff;
      mask_in      = mask_ff;
      flip_in      = flip_ff;
      hshift_in    = hshift_ff;
      entry_in     = entry_ff;
      expanding_in = expanding_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      width_in     = width_ff;
      row_x_in     = row_x_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      code_in      = code_ff;
      color_in     = color_ff;
      eflip_in     = eflip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_tile_in  = rsp_tile_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_color_in = rsp_color_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_flip_in  = rsp_flip_ff;

      if (csr_we) begin
         case (csr_index)
            sle_pkg::CSR_PRI_MATCH: match_in  = csr_wdata[7:0];
            sle_pkg::CSR_PRI_MASK:  mask_in   = csr_wdata[7:0];
            sle_pkg::CSR_FLIP:      flip_in   = csr_wdata[0];
            sle_pkg::CSR_HSHIFT:    hshift_in = csr_wdata;
            default:                match_in  = match_ff;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SPRITE_WORDS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_chan.opcode)
                  sle_pkg::OP_FRAME: begin
                     d2_sel_in    = d1_sel_ff;
                     d1_sel_in    = live_sel_ff;
                     live_sel_in  = d2_sel_ff;
                     entry_in     = '0;
                     expanding_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = ST_COPY;
                  end
                  sle_pkg::OP_STEP: begin
                     state_in = expanding_ff ? ST_TILE : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_COPY: begin
            if (cnt_ff != CNT_W'(SPRITE_WORDS)) begin
               cnt_in     = cnt_ff + CNT_W'(1);
               cp_pend_in = 1'b1;
               cp_addr_in = cnt_ff[ADDR_W-1:0];
            end else if (!cp_pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            state_in = (entry_ff == ENTRY_W'(NUM_ENTRIES)) ? ST_DONE : ST_W0;
         end
         ST_W0: begin
            if (scan_word == '0) begin
               entry_in = entry_ff + ENTRY_W'(1);
               state_in = ST_SCAN;
            end else begin
               state_in = ST_W7;
            end
         end
         ST_W7: begin
            if ((scan_word[15:8] & mask_ff) != match_ff) begin
               entry_in = entry_ff + ENTRY_W'(1);
               state_in = ST_SCAN;
            end else begin
               color_in = scan_word;
               state_in = ST_W1;
            end
         end
         ST_W1: begin
            width_in = scan_word[3:0];
            col_in   = scan_word[3:0];
            row_in   = scan_word[7:4];
            state_in = ST_W3;
         end
         ST_W3: begin
            code_in  = {1'b0, scan_word};
            state_in = ST_W4;
         end
         ST_W4: begin
            row_x_in = alu_res;
            state_in = ST_W6;
         end
         ST_W6: begin
            cur_y_in = {3'b000, scan_word[8:0]};
            eflip_in = flip_ff;
            if (flip_ff) begin
               state_in = ST_FLIP_X;
            end else begin
               cur_x_in     = row_x_ff;
               expanding_in = 1'b1;
               state_in     = ST_TILE;
            end
         end
         ST_FLIP_X: begin
            row_x_in = alu_res;
            cur_x_in = alu_res;
            state_in = ST_FLIP_Y;
         end
         ST_FLIP_Y: begin
            cur_y_in     = alu_res;
            expanding_in = 1'b1;
            state_in     = ST_TILE;
         end
         ST_TILE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_tile_in  = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_code_in  = code_ff;
               rsp_color_in = color_ff;
               rsp_x_in     = {1'b0, x_wrap} - 10'd16;
               rsp_y_in     = cur_y_ff[8:0];
               rsp_flip_in  = eflip_ff;
               code_in      = code_ff + CODE_W'(1);
               if (col_ff != 4'd0) begin
                  col_in   = col_ff - 4'd1;
                  cur_x_in = alu_res;
               end else if (row_ff != 4'd0) begin
                  row_in   = row_ff - 4'd1;
                  col_in   = width_ff;
                  cur_x_in = row_x_ff;
                  cur_y_in = alu_res;
               end else begin
                  expanding_in = 1'b0;
                  entry_in     = entry_ff + ENTRY_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_tile_in  = 1'b0;
               rsp_done_in  = 1'b1;
               rsp_code_in  = '0;
               rsp_color_in = '0;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_flip_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         cp_pend_ff   <= 1'b0;
         live_sel_ff  <= 2'd0;
         d1_sel_ff    <= 2'd1;
         d2_sel_ff    <= 2'd2;
         match_ff     <= '0;
         mask_ff      <= '0;
         flip_ff      <= 1'b0;
         hshift_ff    <= '0;
         entry_ff     <= '0;
         expanding_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         width_ff     <= '0;
         row_x_ff     <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         code_ff      <= '0;
         eflip_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cp_pend_ff   <= cp_pend_in;
         live_sel_ff  <= live_sel_in;
         d1_sel_ff    <= d1_sel_in;
         d2_sel_ff    <= d2_sel_in;
         match_ff     <= match_in;
         mask_ff      <= mask_in;
         flip_ff      <= flip_in;
         hshift_ff    <= hshift_in;
         entry_ff     <= entry_in;
         expanding_ff <= expanding_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         row_x_ff     <= row_x_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         code_ff      <= code_in;
         eflip_ff     <= eflip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cp_addr_ff   <= cp_addr_in;
      color_ff     <= color_in;
      oob_ff       <= oob_in;
      rsp_tile_ff  <= rsp_tile_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_color_ff <= rsp_color_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_flip_ff  <= rsp_flip_in;
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.tile_valid = rsp_tile_ff;
   assign rsp_chan.pass_done  = rsp_done_ff;
   assign rsp_chan.tile_code  = rsp_code_ff;
   assign rsp_chan.color_word = rsp_color_ff;
   assign rsp_chan.pos_x      = rsp_x_ff;
   assign rsp_chan.pos_y      = rsp_y_ff;
   assign rsp_chan.tile_flip  = rsp_flip_ff;

endmodule

// File: src/sle_checker.sv
// ----------------------------------------------------------------------------
// Sprite List Engine Checker
// Port-level properties of the sprite list tile expander, bound to the top.
// ----------------------------------------------------------------------------
module sle_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [1:0]                 req_opcode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       tile_valid,
   input logic                       pass_done,
   input logic [sle_pkg::CODE_W-1:0] tile_code,
   input logic [sle_pkg::WORD_W-1:0] color_word,
   input logic [9:0]                 pos_x,
   input logic [8:0]                 pos_y,
   input logic                       tile_flip
);

   // The clearing pass keeps the request side closed right after reset.
   a_reset_closes_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready high right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(tile_valid) && $stable(pass_done)
         && $stable(tile_code) && $stable(color_word) && $stable(pos_x)
         && $stable(pos_y) && $stable(tile_flip))
      else $error("stalled response changed");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> tile_valid != pass_done)
      else $error("response is neither exactly a tile nor an end of pass");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pass_done |-> tile_code == '0 && color_word == '0 && pos_x == '0
         && pos_y == '0 && !tile_flip)
      else $error("end-of-pass response carries tile fields");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_opcode != sle_pkg::OP_STEP && !rsp_valid
         |=> !rsp_valid)
      else $error("response produced by a non-step transfer");

endmodule

bind sprite_list_tile_expander sle_checker u_sle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_opcode (req_chan.opcode),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .tile_valid (rsp_chan.tile_valid),
   .pass_done  (rsp_chan.pass_done),
   .tile_code  (rsp_chan.tile_code),
   .color_word (rsp_chan.color_word),
   .pos_x      (rsp_chan.pos_x),
   .pos_y      (rsp_chan.pos_y),
   .tile_flip  (rsp_chan.tile_flip)
);

// File: tb/sv/sprite_list_tile_expander_tb.sv
// ----------------------------------------------------------------------------
// Sprite List Tile Expander Testbench
// Drives word writes, frame ends and tile steps through the request channel,
// predicts every tile draw from its own copy of the three sprite stores and
// the walk state, and compares each response transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_list_tile_expander_tb;

   localparam int SPRITE_WORDS   = sle_pkg::SPRITE_WORDS_DEFAULT;
   localparam int ENTRY_COUNT    = SPRITE_WORDS / 8;
   localparam int SETTLE_CYCLES  = SPRITE_WORDS + 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_ITEMS    = 70;
   localparam logic [11:0] FLIP_ORIGIN_X = 12'd368;
   localparam logic [11:0] FLIP_ORIGIN_Y = 12'd240;

   typedef struct packed {
      logic        tile_valid;
      logic        pass_done;
      logic [16:0] tile_code;
      logic [15:0] color_word;
      logic [9:0]  pos_x;
      logic [8:0]  pos_y;
      logic        tile_flip;
   } tile_draw_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [sle_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sle_pkg::CSR_DATA_W-1:0] csr_wdata;

   sle_req_if req_chan ();
   sle_rsp_if rsp_chan ();

   sprite_list_tile_expander #(.SPRITE_WORDS(SPRITE_WORDS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [15:0] live_words [SPRITE_WORDS];
   logic [15:0] shown_one  [SPRITE_WORDS];
   logic [15:0] shown_two  [SPRITE_WORDS];
   int unsigned walk_entry;
   bit          walk_active;
   bit          walk_flip;
   logic [3:0]  cols_left;
   logic [3:0]  rows_left;
   logic [3:0]  tiles_wide;
   logic [11:0] row_x;
   logic [11:0] tile_x;
   logic [11:0] tile_y;
   logic [16:0] tile_num;

   logic [7:0]  cfg_match;
   logic [7:0]  cfg_mask;
   bit          cfg_flip;
   logic [8:0]  cfg_shift;

   tile_draw_type pending_draws [$];
   tile_draw_type last_draw;
   tile_draw_type oldest_draw;
   int            items_sent;
   int            error_count;
   int            burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] shown_at(int unsigned idx);
      if (idx >= SPRITE_WORDS) return 16'h0000;
      return shown_two[idx];
   endfunction

   function automatic bit open_entry(int unsigned base);
      logic [15:0] size_word;
      logic [15:0] attr_word;
      logic [15:0] x_word;
      logic [15:0] y_word;
      logic [11:0] sx;
      logic [11:0] sy;
      size_word = shown_at(base + 1);
      attr_word = shown_at(base + 7);
      x_word = shown_at(base + 4);
      y_word = shown_at(base + 6);
      if (shown_at(base) == 16'h0000) return 1'b0;
      if ((attr_word[15:8] & cfg_mask) != cfg_match) return 1'b0;
      sx = 12'(x_word[8:0]) + 12'(cfg_shift);
      sy = 12'(y_word[8:0]);
      walk_flip = cfg_flip;
      if (walk_flip) begin
         sx = FLIP_ORIGIN_X - sx;
         sy = FLIP_ORIGIN_Y - sy;
      end
      row_x = sx;
      tile_x = sx;
      tile_y = sy;
      tiles_wide = size_word[3:0];
      cols_left = size_word[3:0];
      rows_left = size_word[7:4];
      tile_num = 17'(shown_at(base + 3));
      walk_active = 1'b1;
      return 1'b1;
   endfunction

   function automatic tile_draw_type next_tile_draw();
      tile_draw_type draw;
      logic [11:0]   delta;
      draw = '0;
      while (!walk_active) begin
         if (walk_entry * 8 >= SPRITE_WORDS) begin
            draw.pass_done = 1'b1;
            return draw;
         end
         if (!open_entry(walk_entry * 8)) walk_entry++;
      end
      draw.tile_valid = 1'b1;
      draw.tile_code = tile_num;
      draw.color_word = shown_at(walk_entry * 8 + 7);
      draw.pos_x = {1'b0, tile_x[8:0] + 9'd16} - 10'd16;
      draw.pos_y = tile_y[8:0];
      draw.tile_flip = walk_flip;
      delta = walk_flip ? 12'hff0 : 12'd16;
      tile_num = tile_num + 17'd1;
      if (cols_left != 0) begin
         cols_left--;
         tile_x = tile_x + delta;
      end else if (rows_left != 0) begin
         rows_left--;
         cols_left = tiles_wide;
         tile_x = row_x;
         tile_y = tile_y + delta;
      end else begin
         walk_active = 1'b0;
         walk_entry++;
      end
      return draw;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (error_count < 100)
         $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
      error_count++;
   endtask

   task automatic send_command(input sle_pkg::op_type op, input logic [10:0] addr,
                               input logic [15:0] data);
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.word_address <= addr;
      req_chan.word_data <= data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      case (op)
         sle_pkg::OP_WRITE: begin
            live_words[addr] = data;
         end
         sle_pkg::OP_FRAME: begin
            for (int i = 0; i < SPRITE_WORDS; i++) begin
               shown_two[i] = shown_one[i];
               shown_one[i] = live_words[i];
            end
            walk_entry = 0;
            walk_active = 1'b0;
         end
         sle_pkg::OP_STEP: begin
            last_draw = next_tile_draw();
            pending_draws.push_back(last_draw);
         end
         default: ;
      endcase
      if (op != sle_pkg::OP_IGNORE) items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // The sender is held idle until every pending draw has been received.
   task automatic wait_for_drain(input bit settle);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_draws.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] match, input logic [7:0] mask,
                             input bit flip, input logic [8:0] shift);
      sle_pkg::csr_idx_type reg_id [4];
      logic [8:0]           reg_value [4];
      reg_id = '{sle_pkg::CSR_PRI_MATCH, sle_pkg::CSR_PRI_MASK, sle_pkg::CSR_FLIP,
                 sle_pkg::CSR_HSHIFT};
      reg_value = '{{1'b0, match}, {1'b0, mask}, {8'h00, flip}, shift};
      wait_for_drain(1'b1);
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= reg_id[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_match = match;
      cfg_mask = mask;
      cfg_flip = flip;
      cfg_shift = shift;
   endtask

   task automatic run_walk(input int cap);
      int steps;
      steps = 0;
      while (steps < cap) begin
         send_command(sle_pkg::OP_STEP, 11'($urandom), 16'($urandom));
         steps++;
         if (last_draw.pass_done) break;
      end
      if (last_draw.pass_done)
         repeat ($urandom_range(0, 2))
            send_command(sle_pkg::OP_STEP, 11'($urandom), 16'($urandom));
   endtask

   task automatic clear_live_entries(input bit all);
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (live_words[i * 8] != 16'h0000 && (all || $urandom_range(0, 3) != 0))
            send_command(sle_pkg::OP_WRITE, 11'(i * 8), 16'h0000);
      end
   endtask

   task automatic write_entry(input int unsigned slot, input logic [15:0] tag,
                              input logic [15:0] size, input logic [15:0] code,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] attr);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8), tag);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8 + 1), size);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8 + 3), code);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8 + 4), x);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8 + 6), y);
      send_command(sle_pkg::OP_WRITE, 11'(slot * 8 + 7), attr);
   endtask

   task automatic run_scene();
      int unsigned count;
      int unsigned slot;
      logic [7:0]  pri;
      logic [7:0]  size;
      logic [15:0] tag;
      clear_live_entries(1'b0);
      count = $urandom_range(1, 4);
      repeat (count) begin
         case ($urandom_range(0, 7))
            0: slot = 0;
            1: slot = ENTRY_COUNT - 1;
            default: slot = $urandom_range(0, ENTRY_COUNT - 1);
         endcase
         pri = ($urandom_range(0, 3) != 0) ? ((8'($urandom) & ~cfg_mask) | (cfg_match & cfg_mask))
                                           : 8'($urandom);
         size = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                             : {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2))};
         tag = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
         write_entry(slot, tag, {8'($urandom), size}, 16'($urandom), 16'($urandom),
                     16'($urandom), {pri, 8'($urandom)});
         if ($urandom_range(0, 3) == 0)
            send_command(sle_pkg::OP_WRITE,
                         {8'($urandom), ($urandom_range(0, 1) ? 3'd2 : 3'd5)},
                         16'($urandom));
         if ($urandom_range(0, 7) == 0)
            send_command(sle_pkg::OP_IGNORE, 11'($urandom), 16'($urandom));
      end
      case ($urandom_range(0, 4))
         0: count = 1;
         1: count = 3;
         default: count = 2;
      endcase
      repeat (count) send_command(sle_pkg::OP_FRAME, 11'($urandom), 16'($urandom));
      if ($urandom_range(0, 7) == 0) run_walk($urandom_range(1, 10));
      else run_walk(80);
      if ($urandom_range(0, 5) == 0) wait_for_drain(1'b0);
   endtask

   task automatic test_reset_walk();
      send_command(sle_pkg::OP_STEP, 11'h000, 16'h0000);
      send_command(sle_pkg::OP_IGNORE, 11'h7ff, 16'hffff);
   endtask

   task automatic test_directed_tiles();
      write_entry(0, 16'h0001, 16'h0011, 16'hffff, 16'h01ff, 16'h01ff, 16'hffff);
      write_entry(ENTRY_COUNT - 1, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  16'h00ff);
      send_command(sle_pkg::OP_FRAME, 11'h000, 16'h0000);
      send_command(sle_pkg::OP_FRAME, 11'h7ff, 16'hffff);
      run_walk(10);
   endtask

   // The priority, flip and shift settings change partway through a full-size entry.
   task automatic test_large_entry_latching();
      set_config(8'h3c, 8'hff, 1'b1, 9'h1ff);
      clear_live_entries(1'b1);
      write_entry($urandom_range(0, ENTRY_COUNT - 1), 16'h0001, 16'h00ff, 16'($urandom),
                  16'($urandom), 16'($urandom), {8'h3c, 8'($urandom)});
      send_command(sle_pkg::OP_FRAME, 11'h000, 16'h0000);
      send_command(sle_pkg::OP_FRAME, 11'h000, 16'h0000);
      run_walk(100);
      set_config(8'h00, 8'h00, 1'b0, 9'h000);
      run_walk(300);
   endtask

   task automatic test_random_scenes();
      logic [7:0] match_set [5];
      logic [7:0] mask_set [5];
      bit         flip_set [5];
      logic [8:0] shift_set [5];
      logic [7:0] mask;
      int         target;
      match_set = '{8'h00, 8'hff, 8'h00, 8'h5a, 8'h80};
      mask_set = '{8'h00, 8'hff, 8'hff, 8'hf0, 8'h0f};
      flip_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      shift_set = '{9'd0, 9'd511, 9'd64, 9'd64, 9'd100};
      for (int p = 0; p < 8; p++) begin
         if (p < 5) begin
            set_config(match_set[p], mask_set[p], flip_set[p], shift_set[p]);
         end else begin
            mask = 8'($urandom);
            set_config(8'($urandom) & mask, mask, 1'($urandom), 9'($urandom));
         end
         run_walk($urandom_range(1, 6));
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) run_scene();
      end
   endtask

   task automatic test_noise_items();
      set_config(8'h00, 8'h00, 1'($urandom), 9'($urandom));
      repeat (PHASE_ITEMS) begin
         case ($urandom_range(0, 9))
            0: send_command(sle_pkg::OP_FRAME, 11'($urandom), 16'($urandom));
            1: send_command(sle_pkg::OP_IGNORE, 11'($urandom), 16'($urandom));
            2, 3, 4, 5: send_command(sle_pkg::OP_STEP, 11'($urandom), 16'($urandom));
            default: send_command(sle_pkg::OP_WRITE, 11'($urandom), 16'($urandom));
         endcase
      end
   endtask

   initial begin
      logic [7:0] stall_pattern;
      int         stall_mode;
      int         mode_left;
      rsp_chan.ready <= 1'b0;
      mode_left = 0;
      stall_mode = 0;
      stall_pattern = 8'h01;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
            stall_pattern = 8'($urandom) | 8'h01;
         end
         mode_left--;
         case (stall_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom);
            2: begin
               rsp_chan.ready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("transfer with no pending draw", 32'd0, 32'd1);
         end else begin
            oldest_draw = pending_draws.pop_front();
            if (rsp_chan.tile_valid !== oldest_draw.tile_valid)
               report_mismatch("tile_valid", 32'(oldest_draw.tile_valid),
                               32'(rsp_chan.tile_valid));
            if (rsp_chan.pass_done !== oldest_draw.pass_done)
               report_mismatch("pass_done", 32'(oldest_draw.pass_done),
                               32'(rsp_chan.pass_done));
            if (rsp_chan.tile_code !== oldest_draw.tile_code)
               report_mismatch("tile_code", 32'(oldest_draw.tile_code),
                               32'(rsp_chan.tile_code));
            if (rsp_chan.color_word !== oldest_draw.color_word)
               report_mismatch("color_word", 32'(oldest_draw.color_word),
                               32'(rsp_chan.color_word));
            if (rsp_chan.pos_x !== oldest_draw.pos_x)
               report_mismatch("pos_x", {22'd0, oldest_draw.pos_x}, {22'd0, rsp_chan.pos_x});
            if (rsp_chan.pos_y !== oldest_draw.pos_y)
               report_mismatch("pos_y", 32'(oldest_draw.pos_y), 32'(rsp_chan.pos_y));
            if (rsp_chan.tile_flip !== oldest_draw.tile_flip)
               report_mismatch("tile_flip", 32'(oldest_draw.tile_flip),
                               32'(rsp_chan.tile_flip));
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= sle_pkg::CSR_PRI_MATCH;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= sle_pkg::OP_IGNORE;
      req_chan.word_address <= '0;
      req_chan.word_data <= '0;
      for (int i = 0; i < SPRITE_WORDS; i++) begin
         live_words[i] = 16'h0000;
         shown_one[i] = 16'h0000;
         shown_two[i] = 16'h0000;
      end
      walk_entry = 0;
      walk_active = 1'b0;
      walk_flip = 1'b0;
      cols_left = '0;
      rows_left = '0;
      tiles_wide = '0;
      row_x = '0;
      tile_x = '0;
      tile_y = '0;
      tile_num = '0;
      cfg_match = '0;
      cfg_mask = '0;
      cfg_flip = 1'b0;
      cfg_shift = '0;
      items_sent = 0;
      error_count = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_walk();
      test_directed_tiles();
      test_large_entry_latching();
      test_random_scenes();
      test_noise_items();

      wait_for_drain(1'b0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_draws.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sprite_list_tile_expander.f
src/sle_pkg.sv
src/sle_req_if.sv
src/sle_rsp_if.sv
src/sle_ram.sv
src/sle_alu.sv
src/sprite_list_tile_expander.sv
src/sle_checker.sv
tb/sv/sprite_list_tile_expander_tb.sv
